>>> hdl/bcl_pkg.sv
package bcl_pkg;

  typedef enum logic [1:0] {
    OP_PRESS   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_POLL    = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_ASSERTED = 2'd1,
    PH_GAP      = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    REG_MIN_ASSERT_POLLS  = 2'd0,
    REG_MIN_ASSERT_MS     = 2'd1,
    REG_MIN_RELEASE_POLLS = 2'd2,
    REG_MIN_RELEASE_MS    = 2'd3
  } reg_t;

  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [7:0] COUNT_MAX = 8'd255;

  typedef struct packed {
    logic [7:0]  min_assert_polls;
    logic [15:0] min_assert_ms;
    logic [7:0]  min_release_polls;
    logic [15:0] min_release_ms;
  } cfg_t;

  typedef struct packed {
    logic go;
    op_t  op;
  } cmd_t;

endpackage

>>> hdl/bcl_slot.sv
module bcl_slot (
  input  logic            clk,
  input  logic            rst,
  input  bcl_pkg::cmd_t   cmd,
  input  logic            hit,
  input  logic [31:0]     now_ms,
  input  bcl_pkg::cfg_t   cfg,
  output logic            asserted
);

  bcl_pkg::phase_t phase, phase_next;
  logic [7:0]      poll_count, poll_count_next;
  logic [31:0]     phase_start, phase_start_next;
  logic            click_pending, click_pending_next;
  logic            follow_up_queued, follow_up_queued_next;
  logic            held_down, held_down_next;

  bcl_pkg::phase_t ph1;
  logic [7:0]      cnt1, cnt2;
  logic [31:0]     start1, elapsed;
  logic            pend1, idle_start;

  always_comb begin
    idle_start = (phase == bcl_pkg::PH_IDLE) && (click_pending || held_down);
    ph1    = idle_start ? bcl_pkg::PH_ASSERTED : phase;
    cnt1   = idle_start ? 8'd0 : poll_count;
    start1 = idle_start ? now_ms : phase_start;
    pend1  = idle_start ? 1'b0 : click_pending;
    cnt2   = (cnt1 == bcl_pkg::COUNT_MAX) ? cnt1 : cnt1 + 8'd1;
    elapsed = now_ms - start1;
    asserted = (ph1 == bcl_pkg::PH_ASSERTED);

    phase_next            = phase;
    poll_count_next       = poll_count;
    phase_start_next      = phase_start;
    click_pending_next    = click_pending;
    follow_up_queued_next = follow_up_queued;
    held_down_next        = held_down;

    if (cmd.go) begin
      case (cmd.op)
        bcl_pkg::OP_PRESS: begin
          if (hit) begin
            held_down_next = 1'b1;
            if (phase != bcl_pkg::PH_ASSERTED && phase != bcl_pkg::PH_GAP &&
                !click_pending) begin
              click_pending_next = 1'b1;
            end else begin
              follow_up_queued_next = 1'b1;
            end
          end
        end
        bcl_pkg::OP_RELEASE: begin
          if (hit) begin
            held_down_next = 1'b0;
          end
        end
        bcl_pkg::OP_POLL: begin
          phase_next         = ph1;
          poll_count_next    = cnt1;
          phase_start_next   = start1;
          click_pending_next = pend1;
          if (ph1 == bcl_pkg::PH_ASSERTED) begin
            poll_count_next = cnt2;
            if (!held_down && cnt2 >= cfg.min_assert_polls &&
                elapsed >= {16'd0, cfg.min_assert_ms}) begin
              phase_next       = bcl_pkg::PH_GAP;
              poll_count_next  = 8'd0;
              phase_start_next = now_ms;
            end
          end else if (ph1 == bcl_pkg::PH_GAP) begin
            poll_count_next = cnt2;
            if (cnt2 >= cfg.min_release_polls &&
                elapsed >= {16'd0, cfg.min_release_ms}) begin
              phase_next = bcl_pkg::PH_IDLE;
              if (follow_up_queued) begin
                follow_up_queued_next = 1'b0;
                click_pending_next    = 1'b1;
              end
            end
          end
        end
        bcl_pkg::OP_CLEAR: begin
          phase_next            = bcl_pkg::PH_IDLE;
          poll_count_next       = 8'd0;
          phase_start_next      = 32'd0;
          click_pending_next    = 1'b0;
          follow_up_queued_next = 1'b0;
          held_down_next        = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= bcl_pkg::PH_IDLE;
      poll_count       <= 8'd0;
      phase_start      <= 32'd0;
      click_pending    <= 1'b0;
      follow_up_queued <= 1'b0;
      held_down        <= 1'b0;
    end else begin
      phase            <= phase_next;
      poll_count       <= poll_count_next;
      phase_start      <= phase_start_next;
      click_pending    <= click_pending_next;
      follow_up_queued <= follow_up_queued_next;
      held_down        <= held_down_next;
    end
  end

endmodule

>>> hdl/button_click_latch.sv
// Click latch for up to eight buttons. Press and release items mark a button
// held and queue clicks; each poll item (carrying the millisecond time) steps
// every button through idle, asserted and release gap and returns one item:
// the mask of asserted buttons. Press, release and clear return nothing.
// Items are taken one per cycle while in_stall is low; each passes an input
// register, then a parallel per-button update into the result register, from
// which a poll result is presented. in_stall rises only while a poll waits
// behind an unread, stalled result. Button indices at or above BUTTONS are
// ignored.
module button_click_latch #(
  parameter int BUTTONS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      opcode,
  input  logic [3:0]                      button_index,
  input  logic [31:0]                     now_ms,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      asserted_mask,
  input  logic                            cfg_write,
  input  logic [1:0]                      cfg_index,
  input  logic [bcl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  bcl_pkg::cfg_t cfg;

  logic            s1_valid;
  bcl_pkg::op_t    s1_op;
  logic [3:0]      s1_idx;
  logic [31:0]     s1_now;
  logic            s1_advance;
  bcl_pkg::cmd_t   cmd;
  logic [BUTTONS-1:0] slot_bits;
  logic [7:0]      mask_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_assert_polls  <= 8'd2;
      cfg.min_assert_ms     <= 16'd30;
      cfg.min_release_polls <= 8'd2;
      cfg.min_release_ms    <= 16'd30;
    end else if (cfg_write) begin
      case (bcl_pkg::reg_t'(cfg_index))
        bcl_pkg::REG_MIN_ASSERT_POLLS:  cfg.min_assert_polls  <= cfg_data[7:0];
        bcl_pkg::REG_MIN_ASSERT_MS:     cfg.min_assert_ms     <= cfg_data;
        bcl_pkg::REG_MIN_RELEASE_POLLS: cfg.min_release_polls <= cfg_data[7:0];
        bcl_pkg::REG_MIN_RELEASE_MS:    cfg.min_release_ms    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign s1_advance = s1_valid &&
                      (s1_op != bcl_pkg::OP_POLL || !out_valid || !out_stall);
  assign in_stall   = s1_valid && !s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_op  <= bcl_pkg::op_t'(opcode);
      s1_idx <= button_index;
      s1_now <= now_ms;
    end
  end

  assign cmd.go = s1_advance;
  assign cmd.op = s1_op;

  for (genvar i = 0; i < BUTTONS; i++) begin : g_slot
    bcl_slot u_slot (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .hit      (s1_idx == 4'(i)),
      .now_ms   (s1_now),
      .cfg      (cfg),
      .asserted (slot_bits[i])
    );
  end

  always_comb begin
    mask_next = 8'd0;
    mask_next[BUTTONS-1:0] = slot_bits;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1_op == bcl_pkg::OP_POLL) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_op == bcl_pkg::OP_POLL) begin
      asserted_mask <= mask_next;
    end
  end

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall && s1_op == bcl_pkg::OP_POLL)
    else $error("input stalled without a blocked poll result");

  a_nonpoll_flows: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_op != bcl_pkg::OP_POLL |-> !in_stall)
    else $error("non-poll item held in input register");

  a_poll_result: assert property (@(posedge clk) disable iff (rst)
    s1_advance && s1_op == bcl_pkg::OP_POLL |=> out_valid)
    else $error("poll item produced no result");

  a_mask_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (asserted_mask >> BUTTONS) == 8'd0)
    else $error("mask bit set beyond button count");

endmodule
